### design/pkt_pkg.sv
// shared types and codes for the paired key table
// no dependencies

package pkt_pkg;

   localparam int unsigned ADDR_W  = 48;
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned COUNT_W = 4;

   localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef struct packed {
      logic              address_type;
      logic [ADDR_W-1:0] peer_address;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
   } entry_type;

endpackage

### design/pkt_req_if.sv
// request channel of the paired key table: valid, ready and one operation
// depends on pkt_pkg

interface pkt_req_if
   import pkt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] peer_address;
   logic              address_type;
   logic [KEY_W-1:0]  key_in_low;
   logic [KEY_W-1:0]  key_in_high;

   modport source (output valid, opcode, peer_address, address_type, key_in_low, key_in_high,
                   input ready);
   modport sink   (input valid, opcode, peer_address, address_type, key_in_low, key_in_high,
                   output ready);
endinterface

### design/pkt_rsp_if.sv
// response channel of the paired key table: valid, ready and one result
// depends on pkt_pkg

interface pkt_rsp_if
   import pkt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [KEY_W-1:0]   key_out_low;
   logic [KEY_W-1:0]   key_out_high;
   logic [COUNT_W-1:0] valid_count;

   modport source (output valid, status, key_out_low, key_out_high, valid_count,
                   input ready);
   modport sink   (input valid, status, key_out_low, key_out_high, valid_count,
                   output ready);
endinterface

### design/paired_key_table.sv
// paired key table top level: slot scan sequencer over one entry ram
// depends on pkt_pkg, pkt_req_if, pkt_rsp_if and pkt_ram
//
// channel  dir  handshake          contents
// req_ch   in   valid/ready        opcode, peer_address, address_type, key halves
// rsp_ch   out  valid/ready        status, key halves, valid_count
//
// find and store scan the ram one slot per cycle, and a match ends the scan early
// clear and the unused opcode skip the scan and go straight to the result wait state
// the scan is set by the single ram read port; one transaction is in work at a time
// synchronous reset empties the table; a result waiting on rsp_ch stalls only the next finish

module paired_key_table
   import pkt_pkg::*;
#(
   parameter int unsigned SLOTS = 8
) (
   input  logic      clock,
   input  logic      reset,
   pkt_req_if.sink   req_ch,
   pkt_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
   localparam int unsigned ENTRY_W = $bits(entry_type);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [SLOTS-1:0]   slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               atype_ff, atype_in;
   logic [KEY_W-1:0]   klo_ff, klo_in;
   logic [KEY_W-1:0]   khi_ff, khi_in;

   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [KEY_W-1:0]   res_klo_ff, res_klo_in;
   logic [KEY_W-1:0]   res_khi_ff, res_khi_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]   rsp_klo_ff, rsp_klo_in;
   logic [KEY_W-1:0]   rsp_khi_ff, rsp_khi_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               req_fire;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic               slot_hit;
   logic               slot_free;
   logic               scan_last;
   logic               scan_done;
   logic               out_free;
   logic [CNT_W+3:0]   count_wide;
   logic [COUNT_W-1:0] count_sat;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rd_en = (state_ff == S_SCAN) && (issue_ff != CNT_W'(SLOTS));

   assign slot_hit  = cmp_valid_ff && slot_valid_ff[cmp_idx_ff] &&
                      (rd_entry.address_type == atype_ff) &&
                      (rd_entry.peer_address == addr_ff);
   assign slot_free = cmp_valid_ff && !slot_valid_ff[cmp_idx_ff];
   assign scan_last = cmp_valid_ff && (cmp_idx_ff == IDX_W'(SLOTS - 1));
   assign scan_done = (state_ff == S_SCAN) && (slot_hit || scan_last);

   assign count_wide = (CNT_W + 4)'(count_ff);
   assign count_sat  = (count_wide > (CNT_W + 4)'(COUNT_MAX)) ? COUNT_MAX : count_wide[3:0];

   assign wr_entry.address_type = atype_ff;
   assign wr_entry.peer_address = addr_ff;
   assign wr_entry.key_high     = khi_ff;
   assign wr_entry.key_low      = klo_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_idx_ff;
      if (scan_done && (op_ff == OP_STORE)) begin
         if (slot_hit) begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_ff;
         end else if (free_found_ff) begin
            wr_en   = 1'b1;
            wr_addr = free_idx_ff;
         end else if (slot_free) begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = rd_en;
      cmp_idx_in    = issue_ff[IDX_W-1:0];
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      atype_in      = atype_ff;
      klo_in        = klo_ff;
      khi_in        = khi_ff;
      res_status_in = res_status_ff;
      res_klo_in    = res_klo_ff;
      res_khi_in    = res_khi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_klo_in    = rsp_klo_ff;
      rsp_khi_in    = rsp_khi_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_ch.opcode;
               addr_in       = req_ch.peer_address;
               atype_in      = req_ch.address_type;
               klo_in        = req_ch.key_in_low;
               khi_in        = req_ch.key_in_high;
               issue_in      = '0;
               free_found_in = 1'b0;
               res_status_in = ST_OK;
               res_klo_in    = '0;
               res_khi_in    = '0;
               if ((req_ch.opcode == OP_FIND) || (req_ch.opcode == OP_STORE)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_WAIT;
                  if (req_ch.opcode == OP_CLEAR) begin
                     slot_valid_in = '0;
                     count_in      = '0;
                  end
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (slot_free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (scan_done) begin
               state_in = S_WAIT;
               if (op_ff == OP_FIND) begin
                  if (slot_hit) begin
                     res_status_in = ST_OK;
                     res_klo_in    = rd_entry.key_low;
                     res_khi_in    = rd_entry.key_high;
                  end else begin
                     res_status_in = ST_MISS;
                  end
               end else if (wr_en) begin
                  res_status_in          = ST_OK;
                  slot_valid_in[wr_addr] = 1'b1;
                  if (!slot_hit) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  res_status_in = ST_FULL;
               end
            end
         end
         S_WAIT: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_klo_in    = res_klo_ff;
               rsp_khi_in    = res_khi_ff;
               rsp_count_in  = count_sat;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         count_ff      <= '0;
         issue_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         cmp_valid_ff  <= cmp_valid_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      atype_ff      <= atype_in;
      klo_ff        <= klo_in;
      khi_ff        <= khi_in;
      res_status_ff <= res_status_in;
      res_klo_ff    <= res_klo_in;
      res_khi_ff    <= res_khi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_klo_ff    <= rsp_klo_in;
      rsp_khi_ff    <= rsp_khi_in;
      rsp_count_ff  <= rsp_count_in;
   end

   pkt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.key_out_low  = rsp_klo_ff;
   assign rsp_ch.key_out_high = rsp_khi_ff;
   assign rsp_ch.valid_count  = rsp_count_ff;

   // valid slot count tracks the valid bits
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == int'(count_ff))
      else $error("valid count out of step with valid bits");

   // ram writes only at the end of a store scan
   a_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCAN) && (op_ff == OP_STORE) && scan_done)
      else $error("ram write outside a store scan");

   // a clear empties the table by the next cycle
   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.opcode == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left valid slots");

   // a waiting result is never overwritten
   a_rsp_not_lost : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(rsp_status_ff) &&
                                          $stable(rsp_count_ff))
      else $error("pending result overwritten");

endmodule

### design/pkt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module pkt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/paired_key_table_tb.sv
// testbench for paired_key_table: directed table then random find/store/clear/unused traffic,
// each result checked against the row's expected reply or a slot table kept alongside the dut
// depends on pkt_pkg, pkt_req_if, pkt_rsp_if and the paired_key_table rtl

module paired_key_table_tb;
   import pkt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_SLOTS  = 8;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned ADDR_POOL    = 12;
   localparam int unsigned DIRECTED_N   = 25;

   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
   localparam logic [KEY_W-1:0]  KEY_ONES  = {KEY_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] address;
      logic              atype;
      logic [KEY_W-1:0]  key_low;
      logic [KEY_W-1:0]  key_high;
   } key_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   key_low;
      logic [KEY_W-1:0]   key_high;
      logic [COUNT_W-1:0] count;
   } key_reply_type;

   typedef struct packed {
      key_op_type    op;
      logic          typed;
      key_reply_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pkt_req_if req_ch();
   pkt_rsp_if rsp_ch();

   paired_key_table #(
      .SLOTS(TABLE_SLOTS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // shadow slot table
   logic              slot_used [TABLE_SLOTS];
   logic              slot_type [TABLE_SLOTS];
   logic [ADDR_W-1:0] slot_addr [TABLE_SLOTS];
   logic [KEY_W-1:0]  slot_klo  [TABLE_SLOTS];
   logic [KEY_W-1:0]  slot_khi  [TABLE_SLOTS];

   key_reply_type     key_replies_due[$];
   logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
   int unsigned       mismatch_count = 0;
   int unsigned       calm_left = 0;

   stim_row_type directed_rows [DIRECTED_N] = '{
      '{'{OP_FIND,   48'h0, 1'b0, 64'h0, 64'h0}, 1'b1, '{ST_MISS, 64'h0, 64'h0, 4'd0}},
      '{'{OP_UNUSED, ADDR_ONES, 1'b1, KEY_ONES, KEY_ONES}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd0}},
      '{'{OP_CLEAR,  48'h0, 1'b0, 64'h0, 64'h0}, 1'b1, '{ST_OK, 64'h0, 64'h0, 4'd0}},
      '{'{OP_STORE,  ADDR_ONES, 1'b1, KEY_ONES, KEY_ONES}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd1}},
      '{'{OP_FIND,   ADDR_ONES, 1'b1, 64'h0, 64'h0}, 1'b1,
        '{ST_OK, KEY_ONES, KEY_ONES, 4'd1}},
      '{'{OP_FIND,   ADDR_ONES, 1'b0, 64'h0, 64'h0}, 1'b1, '{ST_MISS, 64'h0, 64'h0, 4'd1}},
      '{'{OP_STORE,  48'h0, 1'b0, 64'h0, 64'h0}, 1'b1, '{ST_OK, 64'h0, 64'h0, 4'd2}},
      '{'{OP_FIND,   48'h0, 1'b0, KEY_ONES, KEY_ONES}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd2}},
      '{'{OP_STORE,  48'h0, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd2}},
      '{'{OP_FIND,   48'h0, 1'b0, 64'h0, 64'h0}, 1'b0, '0},
      '{'{OP_STORE,  48'h1, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, 1'b0, '0},
      '{'{OP_STORE,  48'h1, 1'b1, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE}, 1'b0, '0},
      '{'{OP_STORE,  48'h8000_0000_0000, 1'b0, 64'h1, 64'h8000_0000_0000_0000}, 1'b0, '0},
      '{'{OP_STORE,  48'h5555_5555_5555, 1'b0, 64'h5555_5555_5555_5555, 64'h0}, 1'b0, '0},
      '{'{OP_STORE,  48'hAAAA_AAAA_AAAA, 1'b1, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
      '{'{OP_STORE,  48'h1234_5678_9ABC, 1'b0, 64'hDEAD_BEEF_0000_FFFF, 64'h3C3C_C3C3_0F0F_F0F0},
        1'b0, '0},
      '{'{OP_STORE,  48'h2, 1'b0, KEY_ONES, KEY_ONES}, 1'b1, '{ST_FULL, 64'h0, 64'h0, 4'd8}},
      '{'{OP_FIND,   48'h2, 1'b0, 64'h0, 64'h0}, 1'b1, '{ST_MISS, 64'h0, 64'h0, 4'd8}},
      '{'{OP_STORE,  48'h1, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd8}},
      '{'{OP_FIND,   48'h1, 1'b1, 64'h0, 64'h0}, 1'b0, '0},
      '{'{OP_UNUSED, 48'h1, 1'b1, KEY_ONES, 64'h0}, 1'b1, '{ST_OK, 64'h0, 64'h0, 4'd8}},
      '{'{OP_CLEAR,  ADDR_ONES, 1'b1, KEY_ONES, KEY_ONES}, 1'b1,
        '{ST_OK, 64'h0, 64'h0, 4'd0}},
      '{'{OP_FIND,   48'h1, 1'b1, 64'h0, 64'h0}, 1'b1, '{ST_MISS, 64'h0, 64'h0, 4'd0}},
      '{'{OP_STORE,  ADDR_ONES, 1'b0, 64'h0, KEY_ONES}, 1'b1, '{ST_OK, 64'h0, 64'h0, 4'd1}},
      '{'{OP_CLEAR,  48'h1, 1'b0, KEY_ONES, 64'h0}, 1'b1, '{ST_OK, 64'h0, 64'h0, 4'd0}}
   };

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic key_reply_type predict_slot_op(key_op_type op);
      key_reply_type res;
      int            hit;
      int            free_idx;
      int unsigned   used_n;
      res = '0;
      hit = -1;
      free_idx = -1;
      used_n = 0;
      case (op.opcode)
         OP_FIND: begin
            res.status = ST_MISS;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
               if (hit < 0 && slot_used[s] && slot_type[s] == op.atype &&
                   slot_addr[s] == op.address) begin
                  hit = s;
               end
            end
            if (hit >= 0) begin
               res.status   = ST_OK;
               res.key_low  = slot_klo[hit];
               res.key_high = slot_khi[hit];
            end
         end
         OP_STORE: begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
               if (hit < 0 && slot_used[s] && slot_type[s] == op.atype &&
                   slot_addr[s] == op.address) begin
                  hit = s;
               end
               if (free_idx < 0 && !slot_used[s]) free_idx = s;
            end
            if (hit < 0) hit = free_idx;
            if (hit >= 0) begin
               slot_used[hit] = 1'b1;
               slot_type[hit] = op.atype;
               slot_addr[hit] = op.address;
               slot_klo[hit]  = op.key_low;
               slot_khi[hit]  = op.key_high;
            end else begin
               res.status = ST_FULL;
            end
         end
         OP_CLEAR: begin
            for (int s = 0; s < TABLE_SLOTS; s++) slot_used[s] = 1'b0;
         end
         default: ;
      endcase
      for (int s = 0; s < TABLE_SLOTS; s++) if (slot_used[s]) used_n++;
      res.count = (used_n > COUNT_MAX) ? COUNT_MAX : used_n[COUNT_W-1:0];
      return res;
   endfunction

   function automatic key_op_type random_key_op();
      key_op_type  op;
      logic [63:0] wide;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)      op.opcode = OP_FIND;
      else if (r < 92) op.opcode = OP_STORE;
      else if (r < 96) op.opcode = OP_CLEAR;
      else             op.opcode = OP_UNUSED;
      op.atype = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
         op.address = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      end else begin
         wide = rnd64();
         op.address = wide[ADDR_W-1:0];
      end
      r = $urandom_range(0, 19);
      op.key_low  = (r == 0) ? KEY_ONES : (r == 1) ? '0 : rnd64();
      op.key_high = (r == 2) ? KEY_ONES : (r == 3) ? '0 : rnd64();
      if (op.opcode == OP_CLEAR) begin
         wide = rnd64();
         addr_pool[$urandom_range(2, ADDR_POOL - 1)] = wide[ADDR_W-1:0];
      end
      return op;
   endfunction

   task automatic issue(input key_op_type op, input logic typed, input key_reply_type want);
      key_reply_type pred;
      int unsigned   gap;
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op.opcode;
      req_ch.peer_address <= op.address;
      req_ch.address_type <= op.atype;
      req_ch.key_in_low   <= op.key_low;
      req_ch.key_in_high  <= op.key_high;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pred = predict_slot_op(op);
      key_replies_due.push_back(typed ? want : pred);
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (key_replies_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_sink
      int unsigned stall;
      int unsigned hold_left;
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
      end else if (rsp_ch.ready) begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = stall - 1;
         end else begin
            hold_left = $urandom_range(0, 20);
         end
      end else begin
         rsp_ch.ready <= 1'b1;
         hold_left = $urandom_range(0, 20);
      end
   end

   always @(posedge clock) begin : rsp_check
      key_reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (key_replies_due.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = key_replies_due.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.key_out_low !== want.key_low) begin
               $error("key_out_low expected %h got %h", want.key_low, rsp_ch.key_out_low);
               mismatch_count++;
            end
            if (rsp_ch.key_out_high !== want.key_high) begin
               $error("key_out_high expected %h got %h", want.key_high, rsp_ch.key_out_high);
               mismatch_count++;
            end
            if (rsp_ch.valid_count !== want.count) begin
               $error("valid_count expected %0d got %0d", want.count, rsp_ch.valid_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      key_op_type  op;
      logic [63:0] wide;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_FIND;
      req_ch.peer_address = '0;
      req_ch.address_type = 1'b0;
      req_ch.key_in_low   = '0;
      req_ch.key_in_high  = '0;
      rsp_ch.ready        = 1'b0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         slot_used[s] = 1'b0;
         slot_type[s] = 1'b0;
         slot_addr[s] = '0;
         slot_klo[s]  = '0;
         slot_khi[s]  = '0;
      end
      addr_pool[0] = ADDR_ONES;
      addr_pool[1] = '0;
      for (int i = 2; i < ADDR_POOL; i++) begin
         wide = rnd64();
         addr_pool[i] = wide[ADDR_W-1:0];
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         issue(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
      end
      drain();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         op = random_key_op();
         issue(op, 1'b0, '0);
         if (n % 150 == 149) drain();
      end
      drain();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
